// ===== rtl/fft64_pkg.sv =====
// ----------------------------------------------------------------------------
// fft64_pkg
// Shared types, constants and twiddle table for the 64-point radix-2 FFT.
// ----------------------------------------------------------------------------
package fft64_pkg;

  localparam int POINTS   = 64;
  localparam int LOG2_PTS = 6;
  localparam int HALF_PTS = POINTS / 2;
  localparam int DATA_W   = 24;
  localparam int TW_W     = 16;
  localparam int PROD_W   = DATA_W + TW_W;
  localparam int SAMPLE_W = 16;
  localparam int OUT_W    = 23;

  localparam logic [LOG2_PTS-1:0] LAST_ADDR  = 6'(POINTS - 1);
  localparam logic [4:0]          LAST_BFLY  = 5'(HALF_PTS - 1);
  localparam logic [2:0]          LAST_STAGE = 3'(LOG2_PTS - 1);

  typedef logic [LOG2_PTS-1:0]      addr_t;
  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [TW_W-1:0]   twid_t;

  typedef struct packed {
    twid_t re;
    twid_t im;
  } twiddle_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_BF_RD,
    ST_BF_MUL,
    ST_BF_ADD,
    ST_BF_WA,
    ST_BF_WB,
    ST_UN_RD,
    ST_UN_LD,
    ST_UN_OUT
  } state_t;

  // Commands from the sequencer to the datapath
  typedef struct packed {
    logic       load_wr;
    logic       issue_rd;
    logic       mult;
    logic       add;
    logic       wr_a;
    logic       wr_b;
    logic       unl_rd;
    logic       out_load;
    logic [2:0] stage;
    logic [4:0] bfly;
    addr_t      count;
  } cmd_t;

  function automatic addr_t bit_rev(input addr_t v);
    addr_t r;
    for (int i = 0; i < LOG2_PTS; i++) begin
      r[i] = v[LOG2_PTS-1-i];
    end
    return r;
  endfunction

  // cos and sin of 2*pi*e/64 in Q1.14 for the first quarter turn
  function automatic twiddle_t quarter_tab(input logic [4:0] e);
    twiddle_t t;
    unique case (e)
      5'd0:    t = '{re: 16'sd16384, im: 16'sd0};
      5'd1:    t = '{re: 16'sd16305, im: 16'sd1606};
      5'd2:    t = '{re: 16'sd16069, im: 16'sd3196};
      5'd3:    t = '{re: 16'sd15679, im: 16'sd4756};
      5'd4:    t = '{re: 16'sd15137, im: 16'sd6270};
      5'd5:    t = '{re: 16'sd14449, im: 16'sd7723};
      5'd6:    t = '{re: 16'sd13623, im: 16'sd9102};
      5'd7:    t = '{re: 16'sd12665, im: 16'sd10394};
      5'd8:    t = '{re: 16'sd11585, im: 16'sd11585};
      5'd9:    t = '{re: 16'sd10394, im: 16'sd12665};
      5'd10:   t = '{re: 16'sd9102,  im: 16'sd13623};
      5'd11:   t = '{re: 16'sd7723,  im: 16'sd14449};
      5'd12:   t = '{re: 16'sd6270,  im: 16'sd15137};
      5'd13:   t = '{re: 16'sd4756,  im: 16'sd15679};
      5'd14:   t = '{re: 16'sd3196,  im: 16'sd16069};
      5'd15:   t = '{re: 16'sd1606,  im: 16'sd16305};
      5'd16:   t = '{re: 16'sd0,     im: 16'sd16384};
      default: t = '{re: 16'sd0,     im: 16'sd0};
    endcase
    return t;
  endfunction

  // Second quarter by symmetry: cos negated, sin mirrored
  function automatic twiddle_t twiddle(input logic [4:0] p);
    twiddle_t t;
    if (p <= 5'd16) begin
      t = quarter_tab(p);
    end else begin
      t    = quarter_tab(5'(6'd32 - {1'b0, p}));
      t.re = -t.re;
    end
    return t;
  endfunction

endpackage

// ===== rtl/fft64_ram.sv =====
// ----------------------------------------------------------------------------
// fft64_ram
// Generic RAM: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module fft64_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_a_r;
  logic [WIDTH-1:0] rdata_b_r;

  // Write, and register both reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_a_r <= mem_r[raddr_a];
    rdata_b_r <= mem_r[raddr_b];
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

// ===== rtl/fft64_dpath.sv =====
// ----------------------------------------------------------------------------
// fft64_dpath
// Sample store, butterfly unit with twiddle table and output scaling.
// ----------------------------------------------------------------------------
module fft64_dpath (
  input  logic                                     clk,
  input  fft64_pkg::cmd_t                          cmd,
  input  logic                                     inverse,
  input  logic signed [fft64_pkg::SAMPLE_W-1:0]    sample_re,
  input  logic signed [fft64_pkg::SAMPLE_W-1:0]    sample_im,
  output logic signed [fft64_pkg::OUT_W-1:0]       bin_re,
  output logic signed [fft64_pkg::OUT_W-1:0]       bin_im
);

  localparam int WORD_W = 2 * fft64_pkg::DATA_W;
  localparam logic signed [fft64_pkg::DATA_W:0] OUT_HI =
    (fft64_pkg::DATA_W+1)'(2 ** (fft64_pkg::OUT_W - 1) - 1);
  localparam logic signed [fft64_pkg::DATA_W:0] OUT_LO =
    -(fft64_pkg::DATA_W+1)'(2 ** (fft64_pkg::OUT_W - 1));

  fft64_pkg::addr_t    span, lo_mask, bfly6, addr_a, addr_b, tw_idx;
  fft64_pkg::addr_t    raddr_a, waddr;
  fft64_pkg::twiddle_t tw;
  logic                we;
  logic [WORD_W-1:0]   wdata, rdata_a, rdata_b;
  fft64_pkg::data_t    xa_re, xa_im, xb_re, xb_im;

  fft64_pkg::twid_t    w_re_r, w_im_r;
  fft64_pkg::data_t    xa_re_r, xa_im_r, t_re_r, t_im_r;
  logic signed [fft64_pkg::PROD_W-1:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r;
  logic signed [fft64_pkg::PROD_W:0]   acc_re, acc_im;
  logic signed [fft64_pkg::DATA_W:0]   v_re, v_im;
  logic signed [fft64_pkg::OUT_W-1:0]  bin_re_r, bin_im_r;

  // Butterfly addresses and twiddle index for the current stage
  always_comb begin
    span    = 6'(6'd32 >> cmd.stage);
    lo_mask = span - 6'd1;
    bfly6   = {1'b0, cmd.bfly};
    addr_a  = ((bfly6 & ~lo_mask) << 1) | (bfly6 & lo_mask);
    addr_b  = addr_a | span;
    tw_idx  = fft64_pkg::bit_rev(addr_a >> (3'd5 - cmd.stage));
    tw      = fft64_pkg::twiddle(tw_idx[4:0]);
  end

  // Store port selection
  always_comb begin
    raddr_a = cmd.unl_rd ? fft64_pkg::bit_rev(cmd.count) : addr_a;
    we      = cmd.load_wr | cmd.wr_a | cmd.wr_b;
    priority if (cmd.load_wr) begin
      waddr = cmd.count;
      wdata = {fft64_pkg::DATA_W'(sample_re), fft64_pkg::DATA_W'(sample_im)};
    end else if (cmd.wr_a) begin
      waddr = addr_a;
      wdata = {xa_re_r + t_re_r, xa_im_r + t_im_r};
    end else begin
      waddr = addr_b;
      wdata = {xa_re_r - t_re_r, xa_im_r - t_im_r};
    end
  end

  fft64_ram #(
    .WIDTH (WORD_W),
    .DEPTH (fft64_pkg::POINTS)
  ) u_store (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (addr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  assign xa_re = rdata_a[WORD_W-1:fft64_pkg::DATA_W];
  assign xa_im = rdata_a[fft64_pkg::DATA_W-1:0];
  assign xb_re = rdata_b[WORD_W-1:fft64_pkg::DATA_W];
  assign xb_im = rdata_b[fft64_pkg::DATA_W-1:0];

  // Twiddle products, summed, then rounded to remove the Q1.14 twiddle scale
  always_comb begin
    acc_re = (fft64_pkg::PROD_W+1)'(p_rr_r) - (fft64_pkg::PROD_W+1)'(p_ii_r)
           + (fft64_pkg::PROD_W+1)'(8192);
    acc_im = (fft64_pkg::PROD_W+1)'(p_ri_r) + (fft64_pkg::PROD_W+1)'(p_ir_r)
           + (fft64_pkg::PROD_W+1)'(8192);
  end

  // Inverse scaling by one over the points with rounding
  always_comb begin
    v_re = (fft64_pkg::DATA_W+1)'(xa_re);
    v_im = (fft64_pkg::DATA_W+1)'(xa_im);
    if (inverse) begin
      v_re = (v_re + (fft64_pkg::DATA_W+1)'(fft64_pkg::HALF_PTS)) >>> fft64_pkg::LOG2_PTS;
      v_im = (v_im + (fft64_pkg::DATA_W+1)'(fft64_pkg::HALF_PTS)) >>> fft64_pkg::LOG2_PTS;
    end
  end

  // Butterfly pipeline and output word registers
  always_ff @(posedge clk) begin
    if (cmd.issue_rd) begin
      w_re_r <= tw.re;
      w_im_r <= inverse ? tw.im : -tw.im;
    end
    if (cmd.mult) begin
      xa_re_r <= xa_re;
      xa_im_r <= xa_im;
      p_rr_r  <= w_re_r * xb_re;
      p_ii_r  <= w_im_r * xb_im;
      p_ri_r  <= w_re_r * xb_im;
      p_ir_r  <= w_im_r * xb_re;
    end
    if (cmd.add) begin
      t_re_r <= fft64_pkg::DATA_W'(acc_re >>> 14);
      t_im_r <= fft64_pkg::DATA_W'(acc_im >>> 14);
    end
    if (cmd.out_load) begin
      bin_re_r <= (v_re > OUT_HI) ? fft64_pkg::OUT_W'(OUT_HI) :
                  (v_re < OUT_LO) ? fft64_pkg::OUT_W'(OUT_LO) : fft64_pkg::OUT_W'(v_re);
      bin_im_r <= (v_im > OUT_HI) ? fft64_pkg::OUT_W'(OUT_HI) :
                  (v_im < OUT_LO) ? fft64_pkg::OUT_W'(OUT_LO) : fft64_pkg::OUT_W'(v_im);
    end
  end

  assign bin_re = bin_re_r;
  assign bin_im = bin_im_r;

endmodule

// ===== rtl/fft64_ctrl.sv =====
// ----------------------------------------------------------------------------
// fft64_ctrl
// Sequencer: load count, stage and butterfly counters, unload handshake.
// ----------------------------------------------------------------------------
module fft64_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  output logic            out_last,
  output fft64_pkg::cmd_t cmd
);

  fft64_pkg::state_t state_r, state_nxt;
  logic [2:0]        stage_r, stage_nxt;
  logic [4:0]        bfly_r, bfly_nxt;
  fft64_pkg::addr_t  count_r, count_nxt;

  // Hold state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fft64_pkg::ST_LOAD;
      stage_r <= '0;
      bfly_r  <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      stage_r <= stage_nxt;
      bfly_r  <= bfly_nxt;
      count_r <= count_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    stage_nxt = stage_r;
    bfly_nxt  = bfly_r;
    count_nxt = count_r;
    cmd       = '0;
    cmd.stage = stage_r;
    cmd.bfly  = bfly_r;
    cmd.count = count_r;
    unique case (state_r)
      fft64_pkg::ST_LOAD: begin
        if (in_valid) begin
          cmd.load_wr = 1'b1;
          if (count_r == fft64_pkg::LAST_ADDR) begin
            count_nxt = '0;
            stage_nxt = '0;
            bfly_nxt  = '0;
            state_nxt = fft64_pkg::ST_BF_RD;
          end else begin
            count_nxt = count_r + 6'd1;
          end
        end
      end
      fft64_pkg::ST_BF_RD: begin
        cmd.issue_rd = 1'b1;
        state_nxt    = fft64_pkg::ST_BF_MUL;
      end
      fft64_pkg::ST_BF_MUL: begin
        cmd.mult  = 1'b1;
        state_nxt = fft64_pkg::ST_BF_ADD;
      end
      fft64_pkg::ST_BF_ADD: begin
        cmd.add   = 1'b1;
        state_nxt = fft64_pkg::ST_BF_WA;
      end
      fft64_pkg::ST_BF_WA: begin
        cmd.wr_a  = 1'b1;
        state_nxt = fft64_pkg::ST_BF_WB;
      end
      fft64_pkg::ST_BF_WB: begin
        cmd.wr_b  = 1'b1;
        state_nxt = fft64_pkg::ST_BF_RD;
        if (bfly_r == fft64_pkg::LAST_BFLY) begin
          bfly_nxt = '0;
          if (stage_r == fft64_pkg::LAST_STAGE) begin
            count_nxt = '0;
            state_nxt = fft64_pkg::ST_UN_RD;
          end else begin
            stage_nxt = stage_r + 3'd1;
          end
        end else begin
          bfly_nxt = bfly_r + 5'd1;
        end
      end
      fft64_pkg::ST_UN_RD: begin
        cmd.unl_rd = 1'b1;
        state_nxt  = fft64_pkg::ST_UN_LD;
      end
      fft64_pkg::ST_UN_LD: begin
        cmd.out_load = 1'b1;
        state_nxt    = fft64_pkg::ST_UN_OUT;
      end
      fft64_pkg::ST_UN_OUT: begin
        if (!out_stall) begin
          if (count_r == fft64_pkg::LAST_ADDR) begin
            count_nxt = '0;
            state_nxt = fft64_pkg::ST_LOAD;
          end else begin
            count_nxt = count_r + 6'd1;
            state_nxt = fft64_pkg::ST_UN_RD;
          end
        end
      end
      default: state_nxt = fft64_pkg::ST_LOAD;
    endcase
  end

  assign in_stall  = (state_r != fft64_pkg::ST_LOAD);
  assign out_valid = (state_r == fft64_pkg::ST_UN_OUT);
  assign out_last  = out_valid && (count_r == fft64_pkg::LAST_ADDR);

endmodule

// ===== rtl/fft_radix2_64_point_core.sv =====
// ----------------------------------------------------------------------------
// fft_radix2_64_point_core
// 64-point in-place radix-2 FFT/IFFT with one shared butterfly.
// ----------------------------------------------------------------------------
// A frame is 64 complex Q1.15 words taken one per cycle while in_stall is low.
// After the 64th word the block runs six stages of 32 butterflies on one
// shared butterfly unit, each as read, multiply, round, write upper and write
// lower, the two writes taking turns on the single write port of the sample
// store, then emits 64 bins in natural order, each read, loaded into the
// output register and held while out_stall is high, with out_bin_last on the
// final bin. No new frame is taken until the last bin has gone.
// cfg_transform_inverse selects the inverse transform, scaled by 1/64 with
// rounding; bins saturate to 23 bits.
module fft_radix2_64_point_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_write_en,
  input  logic                                  cfg_transform_inverse,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [fft64_pkg::SAMPLE_W-1:0] in_sample_re,
  input  logic signed [fft64_pkg::SAMPLE_W-1:0] in_sample_im,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [fft64_pkg::OUT_W-1:0]    out_bin_re,
  output logic signed [fft64_pkg::OUT_W-1:0]    out_bin_im,
  output logic                                  out_bin_last
);

  logic            inverse_r;
  fft64_pkg::cmd_t cmd;

  // Mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inverse_r <= 1'b0;
    end else if (cfg_write_en) begin
      inverse_r <= cfg_transform_inverse;
    end
  end

  fft64_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_last  (out_bin_last),
    .cmd       (cmd)
  );

  fft64_dpath u_dpath (
    .clk       (clk),
    .cmd       (cmd),
    .inverse   (inverse_r),
    .sample_re (in_sample_re),
    .sample_im (in_sample_im),
    .bin_re    (out_bin_re),
    .bin_im    (out_bin_im)
  );

`ifndef NO_ASSERTIONS
  // Never take a word while a bin is on offer
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !out_valid) else $error("input open during unload");

  // Last bin flag only with a valid bin
  a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_bin_last |-> out_valid) else $error("bin_last without valid");

  // Input reopens straight after the last bin is taken
  a_reopen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_bin_last |=> !in_stall && !out_valid)
    else $error("input not reopened after frame");
`endif

endmodule
